// ===== hw/rtl/fcgl_pkg.sv =====
// Types and constants shared by the character-to-glyph lookup block.
`timescale 1ns / 1ps
package fcgl_pkg;

  localparam logic [1:0] OP_SEG_WR = 2'd0;
  localparam logic [1:0] OP_OFF_WR = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic REG_TABLE_FORMAT  = 1'b0;
  localparam logic REG_SEGMENT_COUNT = 1'b1;

  localparam logic FMT_SEGMENT = 1'b0;
  localparam logic FMT_GROUP   = 1'b1;

  localparam logic [15:0] NO_OFFSET = 16'hffff;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_SEG_WR,
    KIND_OFF_WR,
    KIND_LOOKUP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] index;
    logic [31:0] code;
    logic [31:0] end_code;
    logic [31:0] delta;
    logic [15:0] half;
  } cmd_t;

  typedef struct packed {
    logic [31:0] start_code;
    logic [31:0] end_code;
    logic [31:0] delta;
    logic [15:0] offset_base;
  } seg_t;

  typedef struct packed {
    logic       table_format;
    logic [8:0] segment_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_HIT,
    ST_WORD
  } back_state_e;

endpackage

// ===== hw/rtl/fcgl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module fcgl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/fcgl_front.sv =====
// Command decoder: classifies an accepted beat and drops those with no effect.
`timescale 1ns / 1ps
module fcgl_front #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned OFFSET_WORDS = 4096
) (
  input  logic               accept_i,
  input  logic [1:0]         op_i,
  input  logic [11:0]        index_i,
  input  logic [31:0]        start_code_i,
  input  logic [31:0]        end_code_i,
  input  logic [31:0]        delta_or_start_glyph_i,
  input  logic [15:0]        offset_start_i,
  input  logic [15:0]        offset_word_i,
  input  logic [31:0]        char_code_i,
  output logic               push_o,
  output fcgl_pkg::cmd_t     cmd_o
);

  logic [31:0] index_ext;

  assign index_ext = {20'b0, index_i};

  always_comb begin
    cmd_o.kind     = fcgl_pkg::KIND_LOOKUP;
    cmd_o.index    = index_i;
    cmd_o.code     = char_code_i;
    cmd_o.end_code = end_code_i;
    cmd_o.delta    = delta_or_start_glyph_i;
    cmd_o.half     = offset_word_i;
    push_o         = 1'b0;
    unique case (op_i)
      fcgl_pkg::OP_SEG_WR: begin
        cmd_o.kind = fcgl_pkg::KIND_SEG_WR;
        cmd_o.code = start_code_i;
        cmd_o.half = offset_start_i;
        push_o     = accept_i && (index_ext < MAX_SEGMENTS);
      end
      fcgl_pkg::OP_OFF_WR: begin
        cmd_o.kind = fcgl_pkg::KIND_OFF_WR;
        push_o     = accept_i && (index_ext < OFFSET_WORDS);
      end
      fcgl_pkg::OP_LOOKUP: begin
        push_o = accept_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fcgl_queue.sv =====
// Short command queue between the decoder and the lookup engine.
`timescale 1ns / 1ps
module fcgl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcgl_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output fcgl_pkg::cmd_t pop_data_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PW = (fcgl_pkg::QUEUE_DEPTH > 1) ? $clog2(fcgl_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(fcgl_pkg::QUEUE_DEPTH + 1);

  fcgl_pkg::cmd_t entry_q [fcgl_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CW'(fcgl_pkg::QUEUE_DEPTH));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(fcgl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(fcgl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/fcgl_back.sv =====
// Lookup engine: table writes, binary search over segments and glyph calculation.
`timescale 1ns / 1ps
module fcgl_back #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned OFFSET_WORDS = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcgl_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  fcgl_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           valid_o,
  output logic [31:0]    glyph_index_o
);

  localparam int unsigned SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned OAW = (OFFSET_WORDS > 1) ? $clog2(OFFSET_WORDS) : 1;
  localparam int unsigned SW  = $clog2(MAX_SEGMENTS + 1) + 1;
  localparam int unsigned SEG_BITS = $bits(fcgl_pkg::seg_t);

  fcgl_pkg::back_state_e state_q, state_d;

  logic signed [SW-1:0] lo_q, lo_d;
  logic signed [SW-1:0] hi_q, hi_d;
  logic signed [SW-1:0] mid_q, mid_d;
  logic signed [SW:0]   mid_sum;
  logic [31:0]          code_q, code_d;
  logic                 res_valid_q, res_valid_d;
  logic [31:0]          res_glyph_q, res_glyph_d;

  logic [31:0]          count_ext;
  logic [31:0]          count_sat;
  logic [31:0]          diff;
  logic [31:0]          pos;
  logic                 pos_ok;
  logic                 above, below;

  logic                 seg_wr_en, seg_rd_en;
  logic [SAW-1:0]       seg_wr_addr;
  fcgl_pkg::seg_t       seg_wr_data, seg_rd;
  logic [SEG_BITS-1:0]  seg_rd_raw;
  logic                 off_wr_en, off_rd_en;
  logic [OAW-1:0]       off_wr_addr;
  logic [15:0]          off_rd_data;

  assign seg_rd    = fcgl_pkg::seg_t'(seg_rd_raw);
  assign count_ext = {23'b0, cfg_i.segment_count};
  assign count_sat = (count_ext > MAX_SEGMENTS) ? MAX_SEGMENTS : count_ext;
  assign mid_sum   = (SW + 1)'(lo_q) + (SW + 1)'(hi_q);
  assign above     = code_q > seg_rd.end_code;
  assign below     = code_q < seg_rd.start_code;
  assign diff      = code_q - seg_rd.start_code;
  assign pos       = {16'b0, seg_rd.offset_base} + diff;
  assign pos_ok    = pos < OFFSET_WORDS;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcgl_pkg::ST_IDLE: begin
        if (!empty_i && cmd_i.kind == fcgl_pkg::KIND_LOOKUP) begin
          state_d = fcgl_pkg::ST_SEARCH;
        end
      end
      fcgl_pkg::ST_SEARCH: begin
        state_d = (hi_q < lo_q) ? fcgl_pkg::ST_IDLE : fcgl_pkg::ST_PROBE;
      end
      fcgl_pkg::ST_PROBE: begin
        if (above) begin
          state_d = fcgl_pkg::ST_SEARCH;
        end else if (below) begin
          state_d = (mid_q == '0) ? fcgl_pkg::ST_IDLE : fcgl_pkg::ST_SEARCH;
        end else begin
          state_d = fcgl_pkg::ST_HIT;
        end
      end
      fcgl_pkg::ST_HIT: begin
        if (cfg_i.table_format == fcgl_pkg::FMT_SEGMENT &&
            seg_rd.offset_base != fcgl_pkg::NO_OFFSET && pos_ok) begin
          state_d = fcgl_pkg::ST_WORD;
        end else begin
          state_d = fcgl_pkg::ST_IDLE;
        end
      end
      fcgl_pkg::ST_WORD: begin
        state_d = fcgl_pkg::ST_IDLE;
      end
      default: begin
        state_d = fcgl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    code_d      = code_q;
    res_valid_d = 1'b0;
    res_glyph_d = res_glyph_q;
    pop_o       = 1'b0;
    seg_wr_en   = 1'b0;
    seg_rd_en   = 1'b0;
    off_wr_en   = 1'b0;
    off_rd_en   = 1'b0;
    seg_wr_addr = SAW'(cmd_i.index);
    off_wr_addr = OAW'(cmd_i.index);
    seg_wr_data.start_code  = cmd_i.code;
    seg_wr_data.end_code    = cmd_i.end_code;
    seg_wr_data.delta       = cmd_i.delta;
    seg_wr_data.offset_base = cmd_i.half;
    unique case (state_q)
      fcgl_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            fcgl_pkg::KIND_SEG_WR: seg_wr_en = 1'b1;
            fcgl_pkg::KIND_OFF_WR: off_wr_en = 1'b1;
            default: begin
              lo_d   = '0;
              hi_d   = SW'(count_sat) - 1'b1;
              code_d = cmd_i.code;
            end
          endcase
        end
      end
      fcgl_pkg::ST_SEARCH: begin
        mid_d = SW'(mid_sum >>> 1);
        if (hi_q < lo_q) begin
          res_valid_d = 1'b1;
          res_glyph_d = '0;
        end else begin
          seg_rd_en = 1'b1;
        end
      end
      fcgl_pkg::ST_PROBE: begin
        if (above) begin
          lo_d = mid_q + 1'b1;
        end else if (below) begin
          hi_d = mid_q - 1'b1;
          if (mid_q == '0) begin
            res_valid_d = 1'b1;
            res_glyph_d = '0;
          end
        end
      end
      fcgl_pkg::ST_HIT: begin
        if (cfg_i.table_format == fcgl_pkg::FMT_GROUP) begin
          res_valid_d = 1'b1;
          res_glyph_d = seg_rd.delta + diff;
        end else if (seg_rd.offset_base == fcgl_pkg::NO_OFFSET) begin
          res_valid_d = 1'b1;
          res_glyph_d = {16'b0, code_q[15:0] + seg_rd.delta[15:0]};
        end else if (!pos_ok) begin
          res_valid_d = 1'b1;
          res_glyph_d = '0;
        end else begin
          off_rd_en = 1'b1;
        end
      end
      fcgl_pkg::ST_WORD: begin
        res_valid_d = 1'b1;
        res_glyph_d = (off_rd_data == '0) ? '0 :
                      {16'b0, off_rd_data + seg_rd.delta[15:0]};
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcgl_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    code_q      <= code_d;
    res_glyph_q <= res_glyph_d;
  end

  fcgl_ram #(
    .WIDTH (SEG_BITS),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i     (clk_i),
    .wr_en_i   (seg_wr_en),
    .wr_addr_i (seg_wr_addr),
    .wr_data_i (SEG_BITS'(seg_wr_data)),
    .rd_en_i   (seg_rd_en),
    .rd_addr_i (mid_d[SAW-1:0]),
    .rd_data_o (seg_rd_raw)
  );

  fcgl_ram #(
    .WIDTH (16),
    .DEPTH (OFFSET_WORDS)
  ) u_off_ram (
    .clk_i     (clk_i),
    .wr_en_i   (off_wr_en),
    .wr_addr_i (off_wr_addr),
    .wr_data_i (cmd_i.half),
    .rd_en_i   (off_rd_en),
    .rd_addr_i (pos[OAW-1:0]),
    .rd_data_o (off_rd_data)
  );

  assign valid_o       = res_valid_q;
  assign glyph_index_o = res_glyph_q;

endmodule

// ===== hw/rtl/font_cmap_glyph_lookup.sv =====
// Top level of the character-to-glyph lookup block.
`timescale 1ns / 1ps
// A command beat is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Segment and offset-word writes retire as the idle state pops them.
// A lookup walks a binary search through the segment RAM's single read port, each probe
// passing through the search and probe states (at most about log2(segment count) + 1 probes,
// nine for 256 segments); the hit state then forms the glyph, and the word state follows when
// an offset word must be read. Each result is shown on glyph_index_o for a single cycle with
// valid_o high; the receiver cannot stall it, and writes and unused commands give no result.
// The user must write configuration only while idle; the block itself does not enforce it.
module font_cmap_glyph_lookup #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned OFFSET_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [11:0] index_i,
  input  logic [31:0] start_code_i,
  input  logic [31:0] end_code_i,
  input  logic [31:0] delta_or_start_glyph_i,
  input  logic [15:0] offset_start_i,
  input  logic [15:0] offset_word_i,
  input  logic [31:0] char_code_i,
  output logic        valid_o,
  output logic [31:0] glyph_index_o
);

  fcgl_pkg::cfg_t cfg_q, cfg_d;
  fcgl_pkg::cmd_t push_cmd, head_cmd;
  logic           accept, push, pop, empty, full;

  assign busy   = full;
  assign accept = start && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        fcgl_pkg::REG_TABLE_FORMAT:  cfg_d.table_format  = cfg_wdata_i[0];
        fcgl_pkg::REG_SEGMENT_COUNT: cfg_d.segment_count = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fcgl_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .OFFSET_WORDS (OFFSET_WORDS)
  ) u_front (
    .accept_i               (accept),
    .op_i                   (op_i),
    .index_i                (index_i),
    .start_code_i           (start_code_i),
    .end_code_i             (end_code_i),
    .delta_or_start_glyph_i (delta_or_start_glyph_i),
    .offset_start_i         (offset_start_i),
    .offset_word_i          (offset_word_i),
    .char_code_i            (char_code_i),
    .push_o                 (push),
    .cmd_o                  (push_cmd)
  );

  fcgl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (empty),
    .full_o      (full)
  );

  fcgl_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .OFFSET_WORDS (OFFSET_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (empty),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .valid_o       (valid_o),
    .glyph_index_o (glyph_index_o)
  );

endmodule
